FILE: rtl/lrp_pkg.sv
// level rectangle packer package: sizes, controller states, datapath operations,
// level and rectangle records and the shared geometry helpers
// no dependencies
package lrp_pkg;

   localparam int MAX_ITEMS  = 64;
   localparam int MAX_LEVELS = 128;
   localparam int COORD_W    = 16;

   localparam int ITEM_IDX_W = $clog2(MAX_ITEMS);
   localparam int ITEM_CNT_W = $clog2(MAX_ITEMS + 1);
   localparam int LVL_IDX_W  = $clog2(MAX_LEVELS);
   localparam int LVL_CNT_W  = $clog2(MAX_LEVELS + 1);
   localparam int HGT_W      = COORD_W + 1;
   localparam int NUM_W      = 6;

   localparam logic CSR_SHEET_WIDTH  = 1'b0;
   localparam logic CSR_SHEET_HEIGHT = 1'b1;

   typedef enum logic [4:0] {
      S_IDLE, S_INIT, S_SEL_START, S_SEL_RD, S_SEL_CMP, S_PICK,
      S_LV_RD, S_LV_CHK, S_OV_RD, S_OV_CHK, S_PLACE, S_NS_RD, S_NS_CHK,
      S_ADD_START, S_ADD_RD, S_ADD_CHK, S_SL_START, S_SL_RD, S_SL_WR,
      S_FIX_RD, S_FIX_LOAD, S_FX_RD, S_FX_CHK, S_FX_WR, S_EMIT_PL, S_EMIT_NO
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_STORE, OP_INIT, OP_SEL_CLR, OP_SEL_RD, OP_SEL_CMP, OP_PICK,
      OP_SWAP, OP_LV_RD, OP_LV_CHK, OP_PL_RD, OP_OV_CHK, OP_PLACE,
      OP_SLIDE_STEP, OP_ADD_START, OP_ADD_RD, OP_LV_SHIFT, OP_LV_INS,
      OP_J_CLR, OP_SL_RD, OP_SL_WR, OP_FIX_RD, OP_FIX_LOAD, OP_FIX_WR,
      OP_EMIT_PL, OP_EMIT_NO
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic sel_last;
      logic li_end;
      logic fit;
      logic pk_end;
      logic overlap;
      logic lh_ne;
      logic nx_zero;
      logic lv_full;
      logic j_zero;
      logic rd_y_gt;
      logic j_end;
      logic rot;
      logic rank_last;
   } status_type;

   typedef struct packed {
      logic [COORD_W-1:0]      x;
      logic [COORD_W-1:0]      y;
      logic signed [HGT_W-1:0] h;
   } level_type;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] w;
      logic [COORD_W-1:0] h;
   } rect_type;

   typedef struct packed {
      logic [COORD_W-1:0] w;
      logic [COORD_W-1:0] h;
   } item_type;

   // point inside rectangle moves to its right edge
   function automatic logic [COORD_W-1:0] slide_x(input logic [COORD_W-1:0] px,
                                                  input logic [COORD_W-1:0] py,
                                                  input rect_type r);
      logic [COORD_W:0] x_end;
      logic [COORD_W:0] y_end;
      x_end = {1'b0, r.x} + {1'b0, r.w};
      y_end = {1'b0, r.y} + {1'b0, r.h};
      if ((r.x <= px) && ({1'b0, px} < x_end) && (r.y <= py) && ({1'b0, py} < y_end)) begin
         slide_x = x_end[COORD_W-1:0];
      end else begin
         slide_x = px;
      end
   endfunction

   // positive-area overlap of two rectangles
   function automatic logic overlap_of(input rect_type a, input rect_type b);
      logic [COORD_W:0] ax_end;
      logic [COORD_W:0] ay_end;
      logic [COORD_W:0] bx_end;
      logic [COORD_W:0] by_end;
      ax_end = {1'b0, a.x} + {1'b0, a.w};
      ay_end = {1'b0, a.y} + {1'b0, a.h};
      bx_end = {1'b0, b.x} + {1'b0, b.w};
      by_end = {1'b0, b.y} + {1'b0, b.h};
      overlap_of = (a.w != '0) && (b.w != '0) && (a.h != '0) && (b.h != '0) &&
                   ({1'b0, a.x} < bx_end) && ({1'b0, b.x} < ax_end) &&
                   ({1'b0, a.y} < by_end) && ({1'b0, b.y} < ay_end);
   endfunction

endpackage

FILE: rtl/lrp_ctrl.sv
// level rectangle packer controller: sequences storing, selection, level scans,
// placement and level upkeep; depends on lrp_pkg
module lrp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                last_item,
   input  lrp_pkg::status_type status,
   output lrp_pkg::cmd_type    cmd,
   output logic                busy
);
   import lrp_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.op = OP_STORE;
               if (last_item) state_in = S_INIT;
            end
         end
         S_INIT: begin
            cmd.op   = OP_INIT;
            state_in = S_SEL_START;
         end
         S_SEL_START: begin
            cmd.op   = OP_SEL_CLR;
            state_in = S_SEL_RD;
         end
         S_SEL_RD: begin
            cmd.op   = OP_SEL_RD;
            state_in = S_SEL_CMP;
         end
         S_SEL_CMP: begin
            cmd.op   = OP_SEL_CMP;
            state_in = status.sel_last ? S_PICK : S_SEL_RD;
         end
         S_PICK: begin
            cmd.op   = OP_PICK;
            state_in = S_LV_RD;
         end
         S_LV_RD: begin
            if (status.li_end) begin
               if (status.rot) begin
                  state_in = S_EMIT_NO;
               end else begin
                  cmd.op = OP_SWAP;
               end
            end else begin
               cmd.op   = OP_LV_RD;
               state_in = S_LV_CHK;
            end
         end
         S_LV_CHK: begin
            cmd.op   = OP_LV_CHK;
            state_in = status.fit ? S_OV_RD : S_LV_RD;
         end
         S_OV_RD: begin
            if (status.pk_end) begin
               state_in = S_PLACE;
            end else begin
               cmd.op   = OP_PL_RD;
               state_in = S_OV_CHK;
            end
         end
         S_OV_CHK: begin
            cmd.op   = OP_OV_CHK;
            state_in = status.overlap ? S_LV_RD : S_OV_RD;
         end
         S_PLACE: begin
            cmd.op = OP_PLACE;
            priority if (!status.lh_ne) state_in = S_SL_START;
            else if (status.nx_zero)    state_in = S_NS_RD;
            else                        state_in = S_ADD_START;
         end
         S_NS_RD: begin
            if (status.pk_end) begin
               state_in = S_ADD_START;
            end else begin
               cmd.op   = OP_PL_RD;
               state_in = S_NS_CHK;
            end
         end
         S_NS_CHK: begin
            cmd.op   = OP_SLIDE_STEP;
            state_in = S_NS_RD;
         end
         S_ADD_START: begin
            if (status.lv_full) begin
               state_in = S_SL_START;
            end else begin
               cmd.op   = OP_ADD_START;
               state_in = S_ADD_RD;
            end
         end
         S_ADD_RD: begin
            if (status.j_zero) begin
               cmd.op   = OP_LV_INS;
               state_in = S_SL_START;
            end else begin
               cmd.op   = OP_ADD_RD;
               state_in = S_ADD_CHK;
            end
         end
         S_ADD_CHK: begin
            if (status.rd_y_gt) begin
               cmd.op   = OP_LV_SHIFT;
               state_in = S_ADD_RD;
            end else begin
               cmd.op   = OP_LV_INS;
               state_in = S_SL_START;
            end
         end
         S_SL_START: begin
            cmd.op   = OP_J_CLR;
            state_in = S_SL_RD;
         end
         S_SL_RD: begin
            if (status.j_end) begin
               state_in = S_FIX_RD;
            end else begin
               cmd.op   = OP_SL_RD;
               state_in = S_SL_WR;
            end
         end
         S_SL_WR: begin
            cmd.op   = OP_SL_WR;
            state_in = S_SL_RD;
         end
         S_FIX_RD: begin
            cmd.op   = OP_FIX_RD;
            state_in = S_FIX_LOAD;
         end
         S_FIX_LOAD: begin
            cmd.op   = OP_FIX_LOAD;
            state_in = S_FX_RD;
         end
         S_FX_RD: begin
            if (status.pk_end) begin
               state_in = S_FX_WR;
            end else begin
               cmd.op   = OP_PL_RD;
               state_in = S_FX_CHK;
            end
         end
         S_FX_CHK: begin
            cmd.op   = OP_SLIDE_STEP;
            state_in = S_FX_RD;
         end
         S_FX_WR: begin
            cmd.op   = OP_FIX_WR;
            state_in = S_EMIT_PL;
         end
         S_EMIT_PL: begin
            cmd.op   = OP_EMIT_PL;
            state_in = status.rank_last ? S_IDLE : S_SEL_START;
         end
         S_EMIT_NO: begin
            cmd.op   = OP_EMIT_NO;
            state_in = status.rank_last ? S_IDLE : S_SEL_START;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != S_IDLE);

endmodule

FILE: rtl/lrp_datapath.sv
// level rectangle packer datapath: item, level and placed-rectangle memories,
// scan counters, geometry compares and result registers; depends on lrp_pkg
module lrp_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  lrp_pkg::cmd_type                  cmd,
   input  logic [lrp_pkg::COORD_W-1:0]       sheet_width,
   input  logic [lrp_pkg::COORD_W-1:0]       sheet_height,
   input  logic [lrp_pkg::COORD_W-1:0]       item_width,
   input  logic [lrp_pkg::COORD_W-1:0]       item_height,
   output lrp_pkg::status_type               status,
   output logic                              rsp_strobe,
   output logic [lrp_pkg::NUM_W-1:0]         rsp_item_number,
   output logic                              rsp_placed,
   output logic                              rsp_rotated,
   output logic [lrp_pkg::COORD_W-1:0]       rsp_pos_x,
   output logic [lrp_pkg::COORD_W-1:0]       rsp_pos_y,
   output logic                              rsp_last_result
);
   import lrp_pkg::*;

   item_type  item_mem [MAX_ITEMS];
   level_type lvl_mem  [MAX_LEVELS];
   rect_type  rect_mem [MAX_ITEMS];

   item_type  item_rd_ff;
   level_type lvl_rd_ff;
   rect_type  rect_rd_ff;

   logic [ITEM_CNT_W-1:0] item_count_ff;
   logic [MAX_ITEMS-1:0]  used_ff;
   logic [ITEM_CNT_W-1:0] k_ff;
   logic [ITEM_CNT_W-1:0] rank_ff;
   logic                  found_ff;
   logic [ITEM_IDX_W-1:0] best_idx_ff;
   item_type              best_ff;

   logic [ITEM_IDX_W-1:0] idx_ff;
   logic [COORD_W-1:0]    cw_ff;
   logic [COORD_W-1:0]    ch_ff;
   logic                  rot_ff;

   logic [LVL_CNT_W-1:0]  lvl_count_ff;
   logic [LVL_CNT_W-1:0]  li_ff;
   logic [LVL_CNT_W-1:0]  j_ff;
   logic [COORD_W-1:0]    lx_ff;
   logic [COORD_W-1:0]    ly_ff;
   logic signed [HGT_W-1:0] lh_ff;

   logic [ITEM_CNT_W-1:0] pc_ff;
   logic [ITEM_CNT_W-1:0] pk_ff;
   logic [COORD_W-1:0]    nx_ff;
   logic [COORD_W-1:0]    ny_ff;
   logic signed [HGT_W-1:0] nh_ff;

   logic                  strobe_ff;
   logic [NUM_W-1:0]      num_ff;
   logic                  placed_ff;
   logic                  rotated_ff;
   logic [COORD_W-1:0]    px_ff;
   logic [COORD_W-1:0]    py_ff;
   logic                  last_ff;

   rect_type              cur_rect;
   logic                  sel_better;
   logic                  lh_lt;
   logic [COORD_W:0]      fit_x;
   logic [COORD_W:0]      fit_y;
   logic                  lvl_we;
   logic [LVL_IDX_W-1:0]  lvl_waddr;
   level_type             lvl_wdata;
   logic [LVL_IDX_W-1:0]  lvl_raddr;
   logic                  lvl_re;
   logic [LVL_CNT_W-1:0]  j_dec;

   // top of a placed rectangle, within the sheet after the fit check
   function automatic logic [COORD_W-1:0] fit_y_place(input logic [COORD_W-1:0] y,
                                                      input logic [COORD_W-1:0] h);
      logic [COORD_W:0] sum;
      sum = {1'b0, y} + {1'b0, h};
      fit_y_place = sum[COORD_W-1:0];
   endfunction

   assign cur_rect   = '{x: lx_ff, y: ly_ff, w: cw_ff, h: ch_ff};
   assign sel_better = !used_ff[k_ff[ITEM_IDX_W-1:0]] &&
                       (!found_ff || (item_rd_ff.h > best_ff.h));
   assign lh_lt      = lh_ff < $signed({1'b0, ch_ff});
   assign fit_x      = {1'b0, cw_ff} + {1'b0, lvl_rd_ff.x};
   assign fit_y      = {1'b0, ch_ff} + {1'b0, lvl_rd_ff.y};
   assign j_dec      = j_ff - 1'b1;

   always_comb begin
      status.sel_last  = (ITEM_CNT_W'(k_ff + 1'b1) == item_count_ff);
      status.li_end    = (li_ff == lvl_count_ff);
      status.fit       = (fit_x <= {1'b0, sheet_width}) && (fit_y <= {1'b0, sheet_height});
      status.pk_end    = (pk_ff == pc_ff);
      status.overlap   = overlap_of(cur_rect, rect_rd_ff);
      status.lh_ne     = (lh_ff != $signed({1'b0, ch_ff}));
      status.nx_zero   = lh_lt || (lx_ff == '0);
      status.lv_full   = (lvl_count_ff >= LVL_CNT_W'(MAX_LEVELS));
      status.j_zero    = (j_ff == '0);
      status.rd_y_gt   = (lvl_rd_ff.y > ny_ff);
      status.j_end     = (j_ff == lvl_count_ff);
      status.rot       = rot_ff;
      status.rank_last = (ITEM_CNT_W'(rank_ff + 1'b1) == item_count_ff);
   end

   // level memory ports
   always_comb begin
      lvl_we    = 1'b0;
      lvl_waddr = j_ff[LVL_IDX_W-1:0];
      lvl_wdata = lvl_rd_ff;
      lvl_re    = 1'b0;
      lvl_raddr = li_ff[LVL_IDX_W-1:0];
      unique case (cmd.op)
         OP_INIT: begin
            lvl_we    = 1'b1;
            lvl_waddr = '0;
            lvl_wdata = '{x: '0, y: '0, h: $signed({1'b0, sheet_height})};
         end
         OP_LV_SHIFT: begin
            lvl_we = 1'b1;
         end
         OP_LV_INS: begin
            lvl_we    = 1'b1;
            lvl_wdata = '{x: nx_ff, y: ny_ff, h: nh_ff};
         end
         OP_SL_WR: begin
            lvl_we    = 1'b1;
            lvl_wdata = '{x: slide_x(lvl_rd_ff.x, lvl_rd_ff.y, cur_rect),
                          y: lvl_rd_ff.y, h: lvl_rd_ff.h};
         end
         OP_FIX_WR: begin
            lvl_we    = 1'b1;
            lvl_waddr = li_ff[LVL_IDX_W-1:0];
            lvl_wdata = '{x: nx_ff, y: ny_ff, h: $signed({1'b0, ch_ff})};
         end
         OP_LV_RD, OP_FIX_RD: begin
            lvl_re = 1'b1;
         end
         OP_ADD_RD: begin
            lvl_re    = 1'b1;
            lvl_raddr = j_dec[LVL_IDX_W-1:0];
         end
         OP_SL_RD: begin
            lvl_re    = 1'b1;
            lvl_raddr = j_ff[LVL_IDX_W-1:0];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (lvl_we) lvl_mem[lvl_waddr] <= lvl_wdata;
      if (lvl_re) lvl_rd_ff <= lvl_mem[lvl_raddr];
   end

   always_ff @(posedge clock) begin
      if ((cmd.op == OP_STORE) && (item_count_ff < ITEM_CNT_W'(MAX_ITEMS))) begin
         item_mem[item_count_ff[ITEM_IDX_W-1:0]] <= '{w: item_width, h: item_height};
      end
      if (cmd.op == OP_SEL_RD) item_rd_ff <= item_mem[k_ff[ITEM_IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_PLACE) rect_mem[pc_ff[ITEM_IDX_W-1:0]] <= cur_rect;
      if (cmd.op == OP_PL_RD) rect_rd_ff <= rect_mem[pk_ff[ITEM_IDX_W-1:0]];
   end

   // control counters
   always_ff @(posedge clock) begin
      if (reset) begin
         item_count_ff <= '0;
         used_ff       <= '0;
         k_ff          <= '0;
         rank_ff       <= '0;
         found_ff      <= 1'b0;
         lvl_count_ff  <= LVL_CNT_W'(1);
         li_ff         <= '0;
         j_ff          <= '0;
         pc_ff         <= '0;
         pk_ff         <= '0;
         rot_ff        <= 1'b0;
         strobe_ff     <= 1'b0;
      end else begin
         strobe_ff <= (cmd.op == OP_EMIT_PL) || (cmd.op == OP_EMIT_NO);
         unique case (cmd.op)
            OP_STORE: begin
               if (item_count_ff < ITEM_CNT_W'(MAX_ITEMS)) item_count_ff <= item_count_ff + 1'b1;
            end
            OP_INIT: begin
               lvl_count_ff <= LVL_CNT_W'(1);
               pc_ff        <= '0;
               used_ff      <= '0;
               rank_ff      <= '0;
            end
            OP_SEL_CLR: begin
               k_ff     <= '0;
               found_ff <= 1'b0;
            end
            OP_SEL_CMP: begin
               if (sel_better) found_ff <= 1'b1;
               k_ff <= k_ff + 1'b1;
            end
            OP_PICK: begin
               used_ff[best_idx_ff] <= 1'b1;
               li_ff  <= '0;
               rot_ff <= 1'b0;
            end
            OP_SWAP: begin
               li_ff  <= '0;
               rot_ff <= 1'b1;
            end
            OP_LV_CHK: begin
               pk_ff <= '0;
               if (!status.fit) li_ff <= li_ff + 1'b1;
            end
            OP_OV_CHK: begin
               if (status.overlap) li_ff <= li_ff + 1'b1;
               else pk_ff <= pk_ff + 1'b1;
            end
            OP_PLACE: begin
               pc_ff <= pc_ff + 1'b1;
               pk_ff <= '0;
            end
            OP_SLIDE_STEP: begin
               pk_ff <= pk_ff + 1'b1;
            end
            OP_ADD_START: begin
               j_ff <= lvl_count_ff;
            end
            OP_LV_SHIFT: begin
               j_ff <= j_dec;
            end
            OP_LV_INS: begin
               lvl_count_ff <= lvl_count_ff + 1'b1;
            end
            OP_J_CLR: begin
               j_ff <= '0;
            end
            OP_SL_WR: begin
               j_ff <= j_ff + 1'b1;
            end
            OP_FIX_LOAD: begin
               pk_ff <= '0;
            end
            OP_EMIT_PL, OP_EMIT_NO: begin
               rank_ff <= rank_ff + 1'b1;
               if (status.rank_last) item_count_ff <= '0;
            end
            default: begin
            end
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_SEL_CMP: begin
            if (sel_better) begin
               best_idx_ff <= k_ff[ITEM_IDX_W-1:0];
               best_ff     <= item_rd_ff;
            end
         end
         OP_PICK: begin
            idx_ff <= best_idx_ff;
            cw_ff  <= best_ff.w;
            ch_ff  <= best_ff.h;
         end
         OP_SWAP: begin
            cw_ff <= ch_ff;
            ch_ff <= cw_ff;
         end
         OP_LV_CHK: begin
            lx_ff <= lvl_rd_ff.x;
            ly_ff <= lvl_rd_ff.y;
            lh_ff <= lvl_rd_ff.h;
         end
         OP_PLACE: begin
            ny_ff <= fit_y_place(ly_ff, ch_ff);
            if (lh_lt) begin
               nx_ff <= '0;
               nh_ff <= -HGT_W'(1);
            end else begin
               nx_ff <= lx_ff;
               nh_ff <= lh_ff - $signed({1'b0, ch_ff});
            end
         end
         OP_SLIDE_STEP: begin
            nx_ff <= slide_x(nx_ff, ny_ff, rect_rd_ff);
         end
         OP_FIX_LOAD: begin
            nx_ff <= lvl_rd_ff.x;
            ny_ff <= lvl_rd_ff.y;
         end
         OP_EMIT_PL: begin
            num_ff     <= NUM_W'(idx_ff);
            placed_ff  <= 1'b1;
            rotated_ff <= rot_ff;
            px_ff      <= lx_ff;
            py_ff      <= ly_ff;
            last_ff    <= status.rank_last;
         end
         OP_EMIT_NO: begin
            num_ff     <= NUM_W'(idx_ff);
            placed_ff  <= 1'b0;
            rotated_ff <= 1'b0;
            px_ff      <= '0;
            py_ff      <= '0;
            last_ff    <= status.rank_last;
         end
         default: begin
         end
      endcase
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_item_number = num_ff;
   assign rsp_placed      = placed_ff;
   assign rsp_rotated     = rotated_ff;
   assign rsp_pos_x       = px_ff;
   assign rsp_pos_y       = py_ff;
   assign rsp_last_result = last_ff;

endmodule

FILE: rtl/level_rectangle_packer.sv
// level rectangle packer top level: sheet size registers on the csr port,
// controller and datapath; depends on lrp_pkg, lrp_ctrl, lrp_datapath
//
// Rectangles are taken one per transfer while busy is low; each is stored while
// the store has room. The transfer marked last_item starts packing: busy stays
// high until every stored rectangle has its result. For each rectangle the
// packer first picks the tallest remaining one, then tries the levels in turn,
// comparing against the placed rectangles at a level that fits, and after a
// placement inserts the new level and pushes the levels clear; these steps scan
// the level and placed-rectangle memories. Each result appears for exactly one
// cycle with rsp_strobe and cannot be held off.
module level_rectangle_packer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [lrp_pkg::COORD_W-1:0]   req_item_width,
   input  logic [lrp_pkg::COORD_W-1:0]   req_item_height,
   input  logic                          req_last_item,
   output logic                          rsp_strobe,
   output logic [lrp_pkg::NUM_W-1:0]     rsp_item_number,
   output logic                          rsp_placed,
   output logic                          rsp_rotated,
   output logic [lrp_pkg::COORD_W-1:0]   rsp_pos_x,
   output logic [lrp_pkg::COORD_W-1:0]   rsp_pos_y,
   output logic                          rsp_last_result,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [2:0]                    csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);
   import lrp_pkg::*;

   logic [COORD_W-1:0] sheet_width_ff;
   logic [COORD_W-1:0] sheet_height_ff;
   logic               csr_wr;
   cmd_type            cmd;
   status_type         status;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         sheet_width_ff  <= COORD_W'(1024);
         sheet_height_ff <= COORD_W'(1024);
      end else if (csr_wr) begin
         unique case (csr_paddr[2])
            CSR_SHEET_WIDTH:  sheet_width_ff  <= csr_pwdata[COORD_W-1:0];
            CSR_SHEET_HEIGHT: sheet_height_ff <= csr_pwdata[COORD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         CSR_SHEET_WIDTH:  csr_prdata = 32'(sheet_width_ff);
         CSR_SHEET_HEIGHT: csr_prdata = 32'(sheet_height_ff);
         default:          csr_prdata = '0;
      endcase
   end

   lrp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .last_item (req_last_item),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy)
   );

   lrp_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sheet_width     (sheet_width_ff),
      .sheet_height    (sheet_height_ff),
      .item_width      (req_item_width),
      .item_height     (req_item_height),
      .status          (status),
      .rsp_strobe      (rsp_strobe),
      .rsp_item_number (rsp_item_number),
      .rsp_placed      (rsp_placed),
      .rsp_rotated     (rsp_rotated),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y),
      .rsp_last_result (rsp_last_result)
   );

`ifndef SYNTH
   a_more_results_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last_result |-> busy)
      else $error("result before end of job while idle");

   a_unplaced_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_placed |-> (rsp_pos_x == '0) && (rsp_pos_y == '0) && !rsp_rotated)
      else $error("unplaced result carries a position");

   a_busy_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start && req_last_item))
      else $error("packing started without a last transfer");
`endif

endmodule

FILE: verif/tb.sv
// self-checking testbench for level_rectangle_packer: random and directed jobs,
// sheet sizes set over the csr port, results checked against an in-bench packer
// depends on lrp_pkg and the level_rectangle_packer rtl
`timescale 1ns / 1ps

module tb;
   import lrp_pkg::*;

   localparam int IDLE_LIMIT = 400000;

   typedef struct {
      logic [COORD_W-1:0] w;
      logic [COORD_W-1:0] h;
      logic               last;
      bit                 drain;
   } rect_req_type;

   typedef struct {
      logic [NUM_W-1:0]   num;
      logic               placed;
      logic               rotated;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic               last;
   } placement_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [COORD_W-1:0] req_item_width = '0;
   logic [COORD_W-1:0] req_item_height = '0;
   logic req_last_item = 1'b0;
   logic rsp_strobe, rsp_placed, rsp_rotated, rsp_last_result;
   logic [NUM_W-1:0] rsp_item_number;
   logic [COORD_W-1:0] rsp_pos_x, rsp_pos_y;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [2:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   level_rectangle_packer dut (.*);

   always #5 clock = ~clock;

   rect_req_type  pending_rects[$];
   placement_type expected_placements[$];
   int errors = 0, rects_sent = 0, results_seen = 0, jobs_done = 0, rotations = 0;
   int misses = 0;
   bit took = 0, burst = 0;
   int gap = 0, idle_cycles = 0;

   // packer state
   longint sheet_w = 1024, sheet_h = 1024;
   longint it_w[MAX_ITEMS], it_h[MAX_ITEMS];
   int n_items = 0;
   longint lv_x[MAX_LEVELS], lv_y[MAX_LEVELS], lv_h[MAX_LEVELS], lv_w[MAX_LEVELS];
   int n_levels;
   longint pr_x[MAX_ITEMS], pr_y[MAX_ITEMS], pr_w[MAX_ITEMS], pr_h[MAX_ITEMS];
   int n_placed;

   task automatic report(input string what, input longint got, input longint want);
      errors++;
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
   endtask

   function automatic void push_clear(inout longint x, input longint y, inout longint w,
                                      input int k);
      longint off;
      off = 0;
      if (pr_x[k] <= x && x < pr_x[k] + pr_w[k] && pr_y[k] <= y && y < pr_y[k] + pr_h[k])
         off = pr_x[k] + pr_w[k] - x;
      x += off;
      w -= off;
   endfunction

   function automatic void push_clear_all(inout longint x, input longint y, inout longint w);
      for (int k = 0; k < n_placed; k++) push_clear(x, y, w, k);
   endfunction

   function automatic bit hits_placed(longint x, longint y, longint w, longint h);
      longint l, r, b, t;
      for (int k = 0; k < n_placed; k++) begin
         l = x > pr_x[k] ? x : pr_x[k];
         r = (x + w) < (pr_x[k] + pr_w[k]) ? (x + w) : (pr_x[k] + pr_w[k]);
         b = y > pr_y[k] ? y : pr_y[k];
         t = (y + h) < (pr_y[k] + pr_h[k]) ? (y + h) : (pr_y[k] + pr_h[k]);
         if (r - l > 0 && t - b > 0) return 1;
      end
      return 0;
   endfunction

   function automatic void insert_level(longint x, longint y, longint h, longint w);
      int at;
      if (n_levels >= MAX_LEVELS) return;
      at = n_levels;
      for (int j = 0; j < n_levels; j++)
         if (lv_y[j] > y) begin
            at = j;
            break;
         end
      for (int j = n_levels; j > at; j--) begin
         lv_x[j] = lv_x[j-1]; lv_y[j] = lv_y[j-1];
         lv_h[j] = lv_h[j-1]; lv_w[j] = lv_w[j-1];
      end
      lv_x[at] = x; lv_y[at] = y; lv_h[at] = h; lv_w[at] = w;
      n_levels++;
   endfunction

   function automatic bit fit_rect(longint w, longint h, output longint ox, output longint oy);
      longint lx, ly, lh, lw, nx, ny, nh, nw, tx, tw;
      int k;
      ox = 0; oy = 0;
      for (int i = 0; i < n_levels; i++) begin
         lx = lv_x[i]; ly = lv_y[i]; lh = lv_h[i]; lw = lv_w[i];
         if (w > lw || ly + h > sheet_h) continue;
         if (hits_placed(lx, ly, w, h)) continue;
         if (n_placed >= MAX_ITEMS) return 0;
         k = n_placed++;
         pr_x[k] = lx; pr_y[k] = ly; pr_w[k] = w; pr_h[k] = h;
         nx = lx; ny = ly + h; nh = lh - h; nw = lw;
         if (lh < h) begin
            nx = 0;
            nw = sheet_w;
         end
         if (lh != h) begin
            if (nx == 0) push_clear_all(nx, ny, nw);
            insert_level(nx, ny, nh, nw);
         end
         for (int j = 0; j < n_levels; j++) begin
            tx = lv_x[j]; tw = lv_w[j];
            push_clear(tx, lv_y[j], tw, k);
            lv_x[j] = tx; lv_w[j] = tw;
         end
         lv_h[i] = h;
         tx = lv_x[i]; tw = lv_w[i];
         push_clear_all(tx, lv_y[i], tw);
         lv_x[i] = tx; lv_w[i] = tw;
         ox = lx; oy = ly;
         return 1;
      end
      return 0;
   endfunction

   function automatic void pack_job();
      int order[MAX_ITEMS];
      int j, idx;
      longint x, y;
      placement_type p;
      lv_x[0] = 0; lv_y[0] = 0; lv_h[0] = sheet_h; lv_w[0] = sheet_w;
      n_levels = 1;
      n_placed = 0;
      for (int i = 0; i < n_items; i++) begin
         j = i;
         while (j > 0 && it_h[order[j-1]] < it_h[i]) begin
            order[j] = order[j-1];
            j--;
         end
         order[j] = i;
      end
      for (int i = 0; i < n_items; i++) begin
         idx = order[i];
         p.num = NUM_W'(idx);
         p.placed = 1'b1;
         p.rotated = 1'b0;
         if (!fit_rect(it_w[idx], it_h[idx], x, y)) begin
            if (fit_rect(it_h[idx], it_w[idx], x, y)) begin
               p.rotated = 1'b1;
            end else begin
               p.placed = 1'b0;
               x = 0;
               y = 0;
            end
         end
         p.x = x[COORD_W-1:0];
         p.y = y[COORD_W-1:0];
         p.last = (i + 1 == n_items);
         expected_placements.push_back(p);
      end
      n_items = 0;
   endfunction

   // monitor: input transfers, csr writes and result checks
   always @(posedge clock) begin
      placement_type e;
      if (!reset) begin
         idle_cycles++;
         if (rsp_strobe) begin
            idle_cycles = 0;
            results_seen++;
            if (expected_placements.size() == 0) begin
               report("unexpected result, item_number", rsp_item_number, -1);
            end else begin
               e = expected_placements.pop_front();
               if (rsp_item_number !== e.num) report("item_number", rsp_item_number, e.num);
               if (rsp_placed !== e.placed) report("placed", rsp_placed, e.placed);
               if (rsp_rotated !== e.rotated) report("rotated", rsp_rotated, e.rotated);
               if (rsp_pos_x !== e.x) report("pos_x", rsp_pos_x, e.x);
               if (rsp_pos_y !== e.y) report("pos_y", rsp_pos_y, e.y);
               if (rsp_last_result !== e.last) report("last_result", rsp_last_result, e.last);
               if (e.rotated) rotations++;
               if (!e.placed) misses++;
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            idle_cycles = 0;
            if (csr_paddr[2] == CSR_SHEET_WIDTH) sheet_w = csr_pwdata[15:0];
            else sheet_h = csr_pwdata[15:0];
         end
         if (start && !busy) begin
            idle_cycles = 0;
            took = 1;
            rects_sent++;
            if (n_items < MAX_ITEMS) begin
               it_w[n_items] = req_item_width;
               it_h[n_items] = req_item_height;
               n_items++;
            end
            if (req_last_item) begin
               jobs_done++;
               pack_job();
            end
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout waiting for a transfer");
            $display("tb NOT OK");
            $finish;
         end
      end
   end

   // driver: one rectangle per transfer, random gaps between transfers
   always @(negedge clock) begin
      logic nstart;
      rect_req_type r;
      nstart = start;
      if (!reset) begin
         if (took) begin
            nstart = 1'b0;
            took = 0;
         end
         if (!nstart) begin
            if (gap > 0) begin
               gap--;
            end else if (pending_rects.size() > 0 && (!pending_rects[0].drain ||
                         (expected_placements.size() == 0 && !busy))) begin
               r = pending_rects.pop_front();
               req_item_width <= r.w;
               req_item_height <= r.h;
               req_last_item <= r.last;
               nstart = 1'b1;
               if ($urandom_range(0, 19) == 0) burst = !burst;
               gap = burst ? 0 : $urandom_range(0, 9);
            end
         end
      end
      start <= nstart;
   end

   task automatic csr_write(input logic idx, input logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic wait_idle();
      while (pending_rects.size() > 0 || expected_placements.size() > 0 || start || busy)
         @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic set_sheet(input int w, input int h);
      wait_idle();
      csr_write(CSR_SHEET_WIDTH, w);
      csr_write(CSR_SHEET_HEIGHT, h);
   endtask

   task automatic queue_rect(input int w, input int h, input bit last, input bit drain = 0);
      rect_req_type r;
      r.w = COORD_W'(w); r.h = COORD_W'(h); r.last = last; r.drain = drain;
      pending_rects.push_back(r);
   endtask

   task automatic queue_job(input int count, input int max_w, input int max_h,
                            input bit drain);
      for (int i = 0; i < count; i++)
         queue_rect($urandom_range(0, 7) == 0 ? $urandom_range(0, 65535)
                                              : $urandom_range(1, max_w),
                    $urandom_range(0, 7) == 0 ? $urandom_range(0, 65535)
                                              : $urandom_range(1, max_h),
                    i == count - 1, drain && i == 0);
   endtask

   initial begin
      int sw, sh;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset sheet, oversized, zero sizes, equal heights, exact fill
      queue_rect(65535, 65535, 1);
      queue_rect(0, 10, 0);
      queue_rect(10, 0, 0);
      queue_rect(512, 300, 0);
      queue_rect(512, 300, 0);
      queue_rect(1024, 1024, 0);
      queue_rect(100, 724, 1);
      queue_rect(1024, 1024, 1, 1);
      set_sheet(100, 50);
      queue_rect(40, 90, 0);
      queue_rect(60, 50, 0);
      queue_rect(30, 20, 0);
      queue_rect(30, 20, 1);
      set_sheet(1, 1);
      queue_rect(1, 1, 0);
      queue_rect(1, 1, 0);
      queue_rect(2, 1, 1);
      set_sheet(65535, 65535);
      queue_rect(65535, 1, 0);
      queue_rect(65534, 65535, 0);
      queue_rect(1, 65535, 1);
      // store full: last mark falls on a dropped rectangle
      set_sheet(20, 20);
      for (int i = 0; i < 66; i++) queue_rect($urandom_range(1, 5), $urandom_range(1, 5), i == 65);

      // random jobs over several sheet sizes
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin sw = $urandom_range(1, 65535); sh = $urandom_range(1, 65535); end
            1: begin sw = $urandom_range(20, 300); sh = $urandom_range(20, 300); end
            2: begin sw = 65535; sh = $urandom_range(1, 65535); end
            default: begin sw = $urandom_range(1, 16); sh = $urandom_range(1, 16); end
         endcase
         set_sheet(sw, sh);
         for (int items = 0; items < 36;) begin
            int cnt;
            cnt = $urandom_range(1, 10);
            queue_job(cnt, sw < 4 ? 4 : sw / 2, sh < 4 ? 4 : sh / 2, $urandom_range(0, 4) == 0);
            items += cnt;
         end
      end
      set_sheet(1024, 1024);
      queue_job(8, 400, 400, 1);

      wait_idle();
      $display("%0d rectangles in %0d jobs, %0d results (%0d rotated, %0d unplaced)",
               rects_sent, jobs_done, results_seen, rotations, misses);
      if (errors == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/lrp_pkg.sv
rtl/lrp_ctrl.sv
rtl/lrp_datapath.sv
rtl/level_rectangle_packer.sv
verif/tb.sv
